// ----- design/bqt_pkg.sv -----
// Shared types, codes and helpers of the best-quality track table.
package bqt_pkg;

    localparam int TABLE_SLOTS_DEFAULT = 64;

    localparam int ID_W    = 64;
    localparam int QUAL_W  = 16;
    localparam int AGE_W   = 11;
    localparam int LIMIT_W = 10;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [QUAL_W-1:0]  THRESHOLD_RESET  = 16'd62259;
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RESET = 10'd100;
    localparam logic [AGE_W-1:0]   AGE_MAX          = 11'd2047;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 7'd127;

    // Operation codes.
    localparam logic [1:0] OP_FRAME_START = 2'd0;
    localparam logic [1:0] OP_DETECT      = 2'd1;
    localparam logic [1:0] OP_FRAME_END   = 2'd2;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_UNSTABLE = 2'd2;
    localparam logic [1:0] STATUS_NONE     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT        = 2'd1;

    typedef struct packed {
        logic              alive;
        logic [ID_W-1:0]   track_id;
        logic [QUAL_W-1:0] best_quality;
        logic [AGE_W-1:0]  miss_age;
    } slot_entry_t;

    // Verdict of the slot unit on one table entry.
    typedef struct packed {
        logic write_back;
        logic hit;
        logic free;
        logic expire;
    } slot_eval_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] value);
        logic [COUNT_W-1:0] result;
        if (value > 32'(COUNT_MAX)) begin
            result = COUNT_MAX;
        end else begin
            result = COUNT_W'(value);
        end
        return result;
    endfunction

endpackage

// ----- design/best_quality_track_table.sv -----
// Top level of the best-quality track table: sequencer, counters and result registers.
//
// The block keeps TABLE_SLOTS tracked-object slots in a single-port-read table and
// serves one command at a time. A command word is taken when start is high and busy
// is low. Frame start (aging) and frame end (expiry) walk the whole table through one
// shared slot unit, one entry per cycle; a stable detection walks the table the same
// way and then writes the found or claimed slot in a commit step. An unstable
// detection and the unused operation code are answered from the idle state without
// a walk. After reset the block sweeps the table once to clear every slot, holding
// busy high meanwhile; configuration writes are taken during that sweep too. Each
// result word is shown on the result ports for exactly one cycle, marked by done, and
// the receiver cannot stall it, so it must take the word in that cycle.
// Configuration writes are always accepted (cfg_ready is tied high) and must only be
// issued while the block is idle.
module best_quality_track_table #(
    parameter int TABLE_SLOTS = bqt_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Command channel.
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       operation,
    input  logic [bqt_pkg::ID_W-1:0]         track_id,
    input  logic                             stable,
    input  logic [bqt_pkg::QUAL_W-1:0]       quality,
    // Result channel.
    output logic                             done,
    output logic [1:0]                       status,
    output logic [bqt_pkg::SLOT_W-1:0]       slot,
    output logic                             created,
    output logic                             best_updated,
    output logic [bqt_pkg::COUNT_W-1:0]      expired_count,
    output logic [bqt_pkg::COUNT_W-1:0]      alive_count,
    // Configuration channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqt_pkg::QUAL_W-1:0]       cfg_data
);
    import bqt_pkg::*;

    localparam int AW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PTR_W = $clog2(TABLE_SLOTS + 1);
    localparam int CW    = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [QUAL_W-1:0]  threshold_reg;
    logic [LIMIT_W-1:0] miss_limit_reg;

    // Latched command word.
    logic [1:0]        op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [QUAL_W-1:0] qual_reg, qual_next;

    // Scan pointer and read pipeline.
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;

    // Lookup results of a detection scan.
    logic              hit_found_reg, hit_found_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    logic [QUAL_W-1:0] hit_best_reg, hit_best_next;
    logic              free_found_reg, free_found_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;

    // Counters.
    logic [CW-1:0] alive_cnt_reg, alive_cnt_next;
    logic [CW-1:0] exp_cnt_reg, exp_cnt_next;

    // Result registers.
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               created_reg, created_next;
    logic               updated_reg, updated_next;
    logic [COUNT_W-1:0] exp_out_reg, exp_out_next;
    logic [COUNT_W-1:0] alive_out_reg, alive_out_next;

    // Table memory and shared unit.
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    slot_entry_t ram_wdata;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    slot_entry_t ram_rdata;
    slot_entry_t unit_entry;
    slot_eval_t  unit_eval;
    logic        qual_pass;

    bqt_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bqt_slot_unit u_unit (
        .operation  (op_reg),
        .track_id   (id_reg),
        .miss_limit (miss_limit_reg),
        .entry      (ram_rdata),
        .new_entry  (unit_entry),
        .eval       (unit_eval)
    );

    assign qual_pass = (qual_reg >= threshold_reg);

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign created       = created_reg;
    assign best_updated  = updated_reg;
    assign expired_count = exp_out_reg;
    assign alive_count   = alive_out_reg;
    assign cfg_ready     = 1'b1;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            miss_limit_reg <= MISS_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_QUALITY_THRESHOLD)
            begin
                threshold_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MISS_LIMIT)
            begin
                miss_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        qual_next       = qual_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_best_next   = hit_best_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        alive_cnt_next  = alive_cnt_reg;
        exp_cnt_next    = exp_cnt_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        slot_next       = slot_reg;
        created_next    = created_reg;
        updated_next    = updated_reg;
        exp_out_next    = exp_out_reg;
        alive_out_next  = alive_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_ptr_reg[AW-1:0];
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the table once after reset so every slot reads as free.
                ram_we    = 1'b1;
                ram_waddr = rd_ptr_reg[AW-1:0];
                ram_wdata = '0;
                if (rd_ptr_reg == PTR_W'(TABLE_SLOTS - 1))
                begin
                    rd_ptr_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = operation;
                    id_next         = track_id;
                    qual_next       = quality;
                    rd_ptr_next     = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    exp_cnt_next    = '0;
                    if ((operation == OP_DETECT) && !stable)
                    begin
                        done_next      = 1'b1;
                        status_next    = STATUS_UNSTABLE;
                        slot_next      = '0;
                        created_next   = 1'b0;
                        updated_next   = 1'b0;
                        exp_out_next   = '0;
                        alive_out_next = sat_count(32'(alive_cnt_reg));
                    end
                    else if (operation == OP_UNUSED)
                    begin
                        done_next      = 1'b1;
                        status_next    = STATUS_DONE;
                        slot_next      = '0;
                        created_next   = 1'b0;
                        updated_next   = 1'b0;
                        exp_out_next   = '0;
                        alive_out_next = sat_count(32'(alive_cnt_reg));
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle; the read data is registered and comes back in the next cycle.
                if (rd_ptr_reg != PTR_W'(TABLE_SLOTS))
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = rd_ptr_reg[AW-1:0];
                    rd_ptr_next    = rd_ptr_reg + PTR_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg[AW-1:0];
                end

                if (pend_reg)
                begin
                    if (unit_eval.write_back)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_addr_reg;
                        ram_wdata = unit_entry;
                    end
                    if (unit_eval.expire)
                    begin
                        exp_cnt_next   = exp_cnt_reg + CW'(1);
                        alive_cnt_next = alive_cnt_reg - CW'(1);
                    end
                    if (unit_eval.hit && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pend_addr_reg;
                        hit_best_next  = ram_rdata.best_quality;
                    end
                    if (unit_eval.free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_addr_reg;
                    end
                end

                if ((rd_ptr_reg == PTR_W'(TABLE_SLOTS)) && !pend_reg)
                begin
                    if (op_reg == OP_DETECT)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next     = ST_IDLE;
                        done_next      = 1'b1;
                        status_next    = STATUS_DONE;
                        slot_next      = '0;
                        created_next   = 1'b0;
                        updated_next   = 1'b0;
                        exp_out_next   = sat_count(32'(exp_cnt_reg));
                        alive_out_next = sat_count(32'(alive_cnt_reg));
                    end
                end
            end
            ST_COMMIT:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                exp_out_next = '0;
                if (hit_found_reg)
                begin
                    // Known track: age restarts, best shot replaced only if this one passes the threshold and beats it.
                    ram_we                 = 1'b1;
                    ram_waddr              = hit_idx_reg;
                    ram_wdata.alive        = 1'b1;
                    ram_wdata.track_id     = id_reg;
                    ram_wdata.miss_age     = '0;
                    ram_wdata.best_quality = hit_best_reg;
                    updated_next           = 1'b0;
                    if (qual_pass && (qual_reg > hit_best_reg))
                    begin
                        ram_wdata.best_quality = qual_reg;
                        updated_next           = 1'b1;
                    end
                    status_next    = STATUS_DONE;
                    slot_next      = SLOT_W'(hit_idx_reg);
                    created_next   = 1'b0;
                    alive_out_next = sat_count(32'(alive_cnt_reg));
                end
                else if (free_found_reg)
                begin
                    // New track claims the lowest free slot.
                    ram_we                 = 1'b1;
                    ram_waddr              = free_idx_reg;
                    ram_wdata.alive        = 1'b1;
                    ram_wdata.track_id     = id_reg;
                    ram_wdata.miss_age     = '0;
                    ram_wdata.best_quality = qual_pass ? qual_reg : '0;
                    updated_next           = qual_pass;
                    alive_cnt_next         = alive_cnt_reg + CW'(1);
                    status_next            = STATUS_DONE;
                    slot_next              = SLOT_W'(free_idx_reg);
                    created_next           = 1'b1;
                    alive_out_next         = sat_count(32'(alive_cnt_reg) + 32'd1);
                end
                else
                begin
                    status_next    = STATUS_FULL;
                    slot_next      = '0;
                    created_next   = 1'b0;
                    updated_next   = 1'b0;
                    alive_out_next = sat_count(32'(alive_cnt_reg));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            op_reg         <= OP_FRAME_START;
            id_reg         <= '0;
            qual_reg       <= '0;
            rd_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_best_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            alive_cnt_reg  <= '0;
            exp_cnt_reg    <= '0;
            done_reg       <= 1'b0;
            status_reg     <= STATUS_DONE;
            slot_reg       <= '0;
            created_reg    <= 1'b0;
            updated_reg    <= 1'b0;
            exp_out_reg    <= '0;
            alive_out_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            qual_reg       <= qual_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_best_reg   <= hit_best_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            alive_cnt_reg  <= alive_cnt_next;
            exp_cnt_reg    <= exp_cnt_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            created_reg    <= created_next;
            updated_reg    <= updated_next;
            exp_out_reg    <= exp_out_next;
            alive_out_reg  <= alive_out_next;
        end
    end

endmodule

// ----- design/bqt_slot_ram.sv -----
// Slot table storage: one write port, one registered read port.
module bqt_slot_ram #(
    parameter int DEPTH = bqt_pkg::TABLE_SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  bqt_pkg::slot_entry_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output bqt_pkg::slot_entry_t rdata
);
    import bqt_pkg::*;

    slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/bqt_slot_unit.sv -----
// Shared slot unit: judges and updates one table entry per cycle of a scan.
module bqt_slot_unit (
    input  logic [1:0]                   operation,
    input  logic [bqt_pkg::ID_W-1:0]     track_id,
    input  logic [bqt_pkg::LIMIT_W-1:0]  miss_limit,
    input  bqt_pkg::slot_entry_t         entry,
    output bqt_pkg::slot_entry_t         new_entry,
    output bqt_pkg::slot_eval_t          eval
);
    import bqt_pkg::*;

    always_comb
    begin
        new_entry = entry;
        eval      = '0;
        unique case (operation)
            OP_FRAME_START:
            begin
                if (entry.alive && (entry.miss_age < AGE_MAX))
                begin
                    new_entry.miss_age = entry.miss_age + AGE_W'(1);
                    eval.write_back    = 1'b1;
                end
            end
            OP_DETECT:
            begin
                eval.hit  = entry.alive && (entry.track_id == track_id);
                eval.free = !entry.alive;
            end
            OP_FRAME_END:
            begin
                // Age is compared against the zero-extended limit.
                if (entry.alive && (entry.miss_age > AGE_W'(miss_limit)))
                begin
                    new_entry       = '0;
                    eval.write_back = 1'b1;
                    eval.expire     = 1'b1;
                end
            end
            default:
            begin
                new_entry = entry;
            end
        endcase
    end

endmodule

// ----- design/bqt_checker.sv -----
// Port-level checker of the best-quality track table, bound to the top level.
module bqt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [1:0]                    status,
    input logic [bqt_pkg::SLOT_W-1:0]    slot,
    input logic                          created,
    input logic                          best_updated,
    input logic [bqt_pkg::COUNT_W-1:0]   expired_count,
    input logic [bqt_pkg::COUNT_W-1:0]   alive_count
);
    import bqt_pkg::*;

    // A taken command either keeps the block busy or returns its word at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("taken command neither started work nor returned a word");

    // A full table reports no slot and changes nothing.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STATUS_FULL) |-> (slot == '0) && !created && !best_updated)
        else $error("table-full word carries a slot or an update");

    // A claimed slot is alive, so the alive count cannot be zero.
    a_created_alive: assert property (@(posedge clk) disable iff (!rst_n)
        done && created |-> (status == STATUS_DONE) && (alive_count != '0))
        else $error("claimed slot without an alive slot");

    // Only a frame end reports expired slots; a detection word carries none.
    a_detect_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        done && (created || best_updated || (status == STATUS_FULL)
                 || (status == STATUS_UNSTABLE)) |-> (expired_count == '0))
        else $error("detection word reports expired slots");

endmodule

bind best_quality_track_table bqt_checker u_bqt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .slot          (slot),
    .created       (created),
    .best_updated  (best_updated),
    .expired_count (expired_count),
    .alive_count   (alive_count)
);

// ----- tb/best_quality_track_table_test.sv -----
// Self-checking testbench of the best-quality track table with a built-in table predictor.
`timescale 1ns / 100ps

module best_quality_track_table_test;
    import bqt_pkg::*;

    localparam int SLOTS = TABLE_SLOTS_DEFAULT;
    // Ids of the random part come from a pool a little larger than the table, so that
    // detections keep hitting live tracks while the table can still run full.
    localparam int ID_POOL = 96;
    // The slowest word is a stable detection, which walks the table and then commits. Add
    // the longest sender gap and the clearing sweep after reset, then take it several times over.
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int REPORT_CAP = 200;
    localparam int SOAK_FRAMES = 40;
    localparam int PHASE_WORDS = 80;
    // Register indexes that map to no register; a write to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic              stable;
        logic [QUAL_W-1:0] quality;
    } track_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic               created;
        logic               best_updated;
        logic [COUNT_W-1:0] expired;
        logic [COUNT_W-1:0] alive;
    } track_outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           operation = OP_FRAME_START;
    logic [ID_W-1:0]      track_id = '0;
    logic                 stable = 1'b0;
    logic [QUAL_W-1:0]    quality = '0;
    logic                 done;
    logic [1:0]           status;
    logic [SLOT_W-1:0]    slot;
    logic                 created;
    logic                 best_updated;
    logic [COUNT_W-1:0]   expired_count;
    logic [COUNT_W-1:0]   alive_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_QUALITY_THRESHOLD;
    logic [QUAL_W-1:0]    cfg_data = '0;

    best_quality_track_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .track_id      (track_id),
        .stable        (stable),
        .quality       (quality),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .created       (created),
        .best_updated  (best_updated),
        .expired_count (expired_count),
        .alive_count   (alive_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Shadow copy of the table and of the two registers. Entries that were never
    // claimed are never read, since every lookup only looks at alive slots.
    logic              shadow_alive [SLOTS];
    logic [ID_W-1:0]   shadow_id    [SLOTS];
    logic [QUAL_W-1:0] shadow_best  [SLOTS];
    logic [AGE_W-1:0]  shadow_age   [SLOTS];
    logic [QUAL_W-1:0] shadow_threshold = THRESHOLD_RESET;
    logic [LIMIT_W-1:0] shadow_limit = MISS_LIMIT_RESET;

    track_cmd_t     command_q[$];   // command words waiting to be driven
    track_outcome_t outcome_q[$];   // result words the table owes us, oldest first
    logic [ID_W-1:0] id_pool [ID_POOL];

    int  mismatches = 0;
    int  stall_cycles = 0;
    bit  calm = 1'b0;               // no sender gaps once set

    initial begin
        for (int j = 0; j < SLOTS; j++) begin
            shadow_alive[j] = 1'b0;
        end
    end

    // Applies one command word to the shadow table and returns the result word that
    // the block must give for it.
    function automatic track_outcome_t table_outcome(input track_cmd_t cmd);
        track_outcome_t res;
        int hit;
        int vacant;
        int n_expired;
        int n_alive;
        res = '0;
        res.status = STATUS_DONE;
        hit = -1;
        vacant = -1;
        n_expired = 0;
        n_alive = 0;
        case (cmd.op)
            OP_FRAME_START: begin
                // Aging saturates instead of wrapping.
                for (int j = 0; j < SLOTS; j++) begin
                    if (shadow_alive[j] && shadow_age[j] != AGE_MAX) begin
                        shadow_age[j] = shadow_age[j] + 1'b1;
                    end
                end
            end
            OP_DETECT: begin
                if (!cmd.stable) begin
                    res.status = STATUS_UNSTABLE;
                end else begin
                    // First alive slot with this id wins; otherwise the lowest free one.
                    for (int j = 0; j < SLOTS; j++) begin
                        if (shadow_alive[j]) begin
                            if (hit < 0 && shadow_id[j] == cmd.id) begin
                                hit = j;
                            end
                        end else if (vacant < 0) begin
                            vacant = j;
                        end
                    end
                    if (hit >= 0) begin
                        shadow_age[hit] = '0;
                        if (cmd.quality >= shadow_threshold && cmd.quality > shadow_best[hit]) begin
                            shadow_best[hit] = cmd.quality;
                            res.best_updated = 1'b1;
                        end
                        res.slot = SLOT_W'(hit);
                    end else if (vacant >= 0) begin
                        shadow_alive[vacant] = 1'b1;
                        shadow_id[vacant] = cmd.id;
                        shadow_age[vacant] = '0;
                        // A new track below the threshold starts with no best shot at all.
                        if (cmd.quality >= shadow_threshold) begin
                            shadow_best[vacant] = cmd.quality;
                            res.best_updated = 1'b1;
                        end else begin
                            shadow_best[vacant] = '0;
                        end
                        res.created = 1'b1;
                        res.slot = SLOT_W'(vacant);
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
            end
            OP_FRAME_END: begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (shadow_alive[j] && shadow_age[j] > AGE_W'(shadow_limit)) begin
                        shadow_alive[j] = 1'b0;
                        n_expired++;
                    end
                end
            end
            default: begin
                // The spare operation code leaves the table alone.
            end
        endcase
        for (int j = 0; j < SLOTS; j++) begin
            if (shadow_alive[j]) begin
                n_alive++;
            end
        end
        res.expired = (n_expired > 127) ? 7'd127 : COUNT_W'(n_expired);
        res.alive = (n_alive > 127) ? 7'd127 : COUNT_W'(n_alive);
        return res;
    endfunction

    // Driver. A word leaves the queue when the channel is free; after launching one,
    // the sender may draw a gap, counted down in gap_left, before the next. The gap runs in
    // clock cycles whether or not the block is busy, so gaps land on every phase of
    // its work, including right behind the short unstable-detection words.
    track_cmd_t live_cmd;
    int gap_left = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                outcome_q.push_back(table_outcome(live_cmd));
            end
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (command_q.size() != 0) begin
                    live_cmd = command_q.pop_front();
                    operation <= live_cmd.op;
                    track_id <= live_cmd.id;
                    stable <= live_cmd.stable;
                    quality <= live_cmd.quality;
                    start <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 4);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string field, input logic [ID_W-1:0] want,
                                input logic [ID_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            // Past the cap a broken block would only flood the log.
            if (mismatches <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        end
    endtask

    // Monitor. The result word is only there for the one cycle that done marks, so it
    // is taken at the edge that ends that cycle and checked against the oldest owed word.
    always @(posedge clk) begin
        track_outcome_t want;
        if (rst_n && done) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, expected nothing, actual status %0d",
                         $time, status);
            end else begin
                want = outcome_q.pop_front();
                report_field("status", ID_W'(want.status), ID_W'(status));
                report_field("slot", ID_W'(want.slot), ID_W'(slot));
                report_field("created", ID_W'(want.created), ID_W'(created));
                report_field("best_updated", ID_W'(want.best_updated), ID_W'(best_updated));
                report_field("expired_count", ID_W'(want.expired), ID_W'(expired_count));
                report_field("alive_count", ID_W'(want.alive), ID_W'(alive_count));
            end
        end
    end

    // Watchdog: any command, result or register write counts as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired after %0d idle cycles", $time, stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                             input logic stb, input logic [QUAL_W-1:0] q);
        track_cmd_t cmd;
        cmd.op = op;
        cmd.id = id;
        cmd.stable = stb;
        cmd.quality = q;
        command_q.push_back(cmd);
    endtask

    // Returns once every queued word has gone out and every owed result has come back.
    // Checked on the falling edge so that the driver's edge updates have settled.
    task automatic wait_idle();
        do @(negedge clk);
        while (command_q.size() != 0 || start || outcome_q.size() != 0);
    endtask

    // Register write over the configuration channel; only called while the table is
    // idle. Ends on a falling edge so the caller can queue words without racing the
    // driver.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QUAL_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_QUALITY_THRESHOLD) begin
            shadow_threshold = data;
        end else if (idx == CFG_MISS_LIMIT) begin
            shadow_limit = data[LIMIT_W-1:0];
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Quality picks cluster on the threshold edge and the range ends.
    function automatic logic [QUAL_W-1:0] pick_quality();
        logic [QUAL_W-1:0] q;
        case ($urandom_range(0, 7))
            0: q = shadow_threshold;
            1: q = (shadow_threshold == 16'h0000) ? 16'h0000 : shadow_threshold - 1'b1;
            2: q = (shadow_threshold == 16'hFFFF) ? 16'hFFFF : shadow_threshold + 1'b1;
            3: q = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: q = QUAL_W'($urandom);
        endcase
        return q;
    endfunction

    // Random traffic is mostly stable detections of known tracks, spread among frame
    // starts and frame ends, with some unstable detections, unknown ids and spare codes.
    function automatic track_cmd_t random_cmd();
        track_cmd_t cmd;
        int roll;
        roll = $urandom_range(0, 99);
        cmd.id = id_pool[$urandom_range(0, ID_POOL - 1)];
        if ($urandom_range(0, 9) == 0) begin
            cmd.id = {$urandom, $urandom};
        end
        cmd.quality = pick_quality();
        cmd.stable = 1'b1;
        if (roll < 58) begin
            cmd.op = OP_DETECT;
        end else if (roll < 64) begin
            cmd.op = OP_DETECT;
            cmd.stable = 1'b0;
        end else begin
            if (roll < 80) begin
                cmd.op = OP_FRAME_START;
            end else if (roll < 95) begin
                cmd.op = OP_FRAME_END;
            end else begin
                cmd.op = OP_UNUSED;
            end
            cmd.stable = 1'($urandom_range(0, 1));
        end
        return cmd;
    endfunction

    initial begin
        logic [ID_W-1:0] soak_id;
        logic [LIMIT_W-1:0] lim;
        logic [QUAL_W-1:0] thr;

        for (int j = 0; j < ID_POOL; j++) begin
            id_pool[j] = {$urandom, $urandom};
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run at the reset register values.
        queue_cmd(OP_DETECT, 64'h0, 1'b1, 16'h0000);                  // claim below threshold
        queue_cmd(OP_DETECT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF); // claim as best shot
        queue_cmd(OP_DETECT, 64'h0, 1'b1, 16'hFFFF);                  // found, improves
        queue_cmd(OP_DETECT, 64'h0, 1'b1, THRESHOLD_RESET);           // found, not better
        queue_cmd(OP_DETECT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, THRESHOLD_RESET - 1'b1);
        queue_cmd(OP_DETECT, 64'h5555_5555_5555_5555, 1'b1, THRESHOLD_RESET);
        queue_cmd(OP_DETECT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 16'hFFFF);   // unstable
        queue_cmd(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF);
        queue_cmd(OP_FRAME_START, 64'h0, 1'b0, 16'h0000);
        queue_cmd(OP_FRAME_END, 64'h0, 1'b0, 16'h0000);
        queue_cmd(OP_DETECT, 64'h8000_0000_0000_0000, 1'b1, 16'h0001);
        wait_idle();

        // A zero miss limit expires anything aged by even one frame, and a zero
        // threshold lets a zero quality count as a best shot once but never improve.
        write_reg(CFG_MISS_LIMIT, 16'h0000);
        write_reg(CFG_QUALITY_THRESHOLD, 16'h0000);
        queue_cmd(OP_FRAME_START, 64'h0, 1'b1, 16'hFFFF);
        queue_cmd(OP_FRAME_END, 64'h0, 1'b1, 16'hFFFF);
        queue_cmd(OP_DETECT, 64'h0123_4567_89AB_CDEF, 1'b1, 16'h0000);
        queue_cmd(OP_DETECT, 64'h0123_4567_89AB_CDEF, 1'b1, 16'h0000);
        queue_cmd(OP_FRAME_END, 64'h0, 1'b0, 16'h0000);
        queue_cmd(OP_DETECT, 64'h0123_4567_89AB_CDEF, 1'b0, 16'h0000);
        wait_idle();

        // Fill the table with distinct tracks until it overflows. The spare register
        // indexes are written on the way and must leave both registers alone.
        write_reg(CFG_QUALITY_THRESHOLD, 16'hFFFF);
        write_reg(CFG_MISS_LIMIT, 16'h03FF);
        write_reg(CFG_UNMAPPED_LO, QUAL_W'($urandom));
        write_reg(CFG_UNMAPPED_HI, QUAL_W'($urandom));
        for (int j = 0; j < SLOTS + 2; j++) begin
            queue_cmd(OP_DETECT, {$urandom, $urandom}, 1'b1, (j % 2 == 0) ? 16'hFFFF : 16'hFFFE);
        end
        queue_cmd(OP_DETECT, 64'h0123_4567_89AB_CDEF, 1'b1, 16'hFFFF); // still found when full
        queue_cmd(OP_FRAME_END, 64'h0, 1'b1, 16'h0000);
        wait_idle();

        // Only the low ten bits of the data reach the miss limit, so this is zero and
        // the next frame end empties the whole table.
        write_reg(CFG_MISS_LIMIT, 16'hFC00);
        queue_cmd(OP_FRAME_START, 64'h0, 1'b0, 16'h0000);
        queue_cmd(OP_FRAME_END, 64'h0, 1'b0, 16'h0000);
        wait_idle();

        // Random part in phases, each under its own register setting. Every phase
        // boundary holds the sender until all owed results are back.
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: thr = 16'h0000;
                2: thr = 16'hFFFF;
                3: thr = THRESHOLD_RESET;
                default: thr = QUAL_W'($urandom);
            endcase
            case (p)
                0: lim = 10'd3;
                1: lim = 10'd0;
                2: lim = 10'd1023;
                4: lim = 10'd1;
                default: lim = LIMIT_W'($urandom_range(0, 8));
            endcase
            write_reg(CFG_QUALITY_THRESHOLD, thr);
            write_reg(CFG_MISS_LIMIT, {6'($urandom), lim});
            for (int k = 0; k < PHASE_WORDS; k++) begin
                command_q.push_back(random_cmd());
            end
            wait_idle();
        end

        // Closing part without sender gaps: one track goes unseen for a run of frames,
        // outlives the frame ends under the widest miss limit and is then found again.
        calm = 1'b1;
        write_reg(CFG_MISS_LIMIT, 16'hFFFF);
        write_reg(CFG_QUALITY_THRESHOLD, pick_quality());
        soak_id = {$urandom, $urandom};
        queue_cmd(OP_DETECT, soak_id, 1'b1, pick_quality());
        for (int k = 0; k < SOAK_FRAMES; k++) begin
            queue_cmd(OP_FRAME_START, {$urandom, $urandom}, 1'($urandom), QUAL_W'($urandom));
        end
        queue_cmd(OP_FRAME_END, 64'h0, 1'b1, 16'h0000);
        queue_cmd(OP_FRAME_END, 64'h0, 1'b0, 16'h0000);
        queue_cmd(OP_DETECT, soak_id, 1'b1, 16'hFFFF);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bqt_pkg.sv
design/bqt_slot_ram.sv
design/bqt_slot_unit.sv
design/best_quality_track_table.sv
design/bqt_checker.sv
tb/best_quality_track_table_test.sv
